FILE: hw/rtl/htd_pkg.sv
// Shared types and constants of the Huffman tree-table decoder.
package htd_pkg;

  // Command codes carried on the command input.
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdDecode = 1'b1;

  // Code bits carried by one compressed byte.
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCountW   = 4;

  // Classification of the child reached by one tree step.
  typedef struct packed {
    logic leaf;     // child is a symbol
    logic outside;  // child index lies beyond the tree
  } step_flags_t;

endpackage

FILE: hw/rtl/htd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module htd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/htd_step.sv
// One tree step: picks the child for the current code bit and classifies it.
module htd_step #(
  parameter int unsigned NUM_SYMBOLS = 256,
  parameter int unsigned TREE_NODES  = 511
) (
  input  logic [$clog2(TREE_NODES)-1:0] left_child_i,
  input  logic [$clog2(TREE_NODES)-1:0] right_child_i,
  input  logic                          code_bit_i,
  output logic [$clog2(TREE_NODES)-1:0] child_o,
  output logic [$clog2(TREE_NODES)-1:0] next_walk_o,
  output htd_pkg::step_flags_t          flags_o
);

  localparam int unsigned NodeW = $clog2(TREE_NODES);
  localparam logic [NodeW-1:0] RootNode = NodeW'(TREE_NODES - 1);

  logic [NodeW-1:0] child;

  always_comb begin
    child           = code_bit_i ? right_child_i : left_child_i;
    flags_o.leaf    = {1'b0, child} < (NodeW + 1)'(NUM_SYMBOLS);
    flags_o.outside = {1'b0, child} >= (NodeW + 1)'(TREE_NODES);
    // A symbol or an index beyond the tree sends the walk back to the root.
    next_walk_o     = (flags_o.leaf || flags_o.outside) ? RootNode : child;
    child_o         = child;
  end

endmodule

FILE: hw/rtl/huffman_tree_table_decode_top.sv
// Top level of the Huffman tree-walk decoder with a child-index table.
//
// The block decodes a Huffman bit stream against a full code tree whose
// internal nodes are held as a left/right child table in one RAM. A write
// transfer (command 0) stores both children of one internal node and always
// returns the walk to the root. A decode transfer (command 1) brings one
// byte and a count of code bits, saturated to eight; the low-order bits
// given by the count are walked from the most significant one down. One
// table lookup is done per code bit through the shared step unit: the read
// for the first bit is issued as the byte is accepted, each walk step reads
// the next node, and a flush state closes the byte. A step that reaches a
// symbol stalls while another is held and the output register is not free.
// A decode with no code bits completes in its own cycle. The input is not
// ready while a byte is being walked. Each symbol reached leaves as one
// output transfer; the last symbol of a byte carries last_of_byte, so a
// symbol is held back until it is known whether another follows.
// The walk position persists across bytes. Table entries must be written
// before the walk reaches them; reads of unwritten entries return garbage.
module huffman_tree_table_decode_top #(
  parameter int unsigned NUM_SYMBOLS = 256,
  parameter int unsigned TREE_NODES  = 511
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [$clog2(TREE_NODES)-1:0] node_index_i,
  input  logic [$clog2(TREE_NODES)-1:0] left_child_i,
  input  logic [$clog2(TREE_NODES)-1:0] right_child_i,
  input  logic [7:0]                    code_byte_i,
  input  logic [3:0]                    valid_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [$clog2(NUM_SYMBOLS)-1:0] symbol_o,
  output logic                          last_of_byte_o
);

  localparam int unsigned NodeW    = $clog2(TREE_NODES);
  localparam int unsigned SymW     = $clog2(NUM_SYMBOLS);
  localparam int unsigned IntNodes = TREE_NODES - NUM_SYMBOLS;
  localparam int unsigned AddrW    = (IntNodes > 1) ? $clog2(IntNodes) : 1;
  localparam logic [NodeW-1:0] RootNode      = NodeW'(TREE_NODES - 1);
  localparam logic [NodeW-1:0] FirstInternal = NodeW'(NUM_SYMBOLS);
  localparam int unsigned CntW = htd_pkg::BitCountW;
  localparam logic [CntW-1:0] MaxBits = CntW'(htd_pkg::BitsPerByte);

  // Sequencer states.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [NodeW-1:0] walk_q, walk_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       byte_q, byte_d;
  logic             pend_valid_q, pend_valid_d;
  logic [SymW-1:0]  pend_sym_q, pend_sym_d;
  logic             out_valid_q, out_valid_d;
  logic [SymW-1:0]  out_sym_q, out_sym_d;
  logic             out_last_q, out_last_d;

  logic                 in_xfer;
  logic                 wr_internal;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [NodeW-1:0]     waddr_off, raddr_node, raddr_off;
  logic [2*NodeW-1:0]   ram_rdata;
  logic [CntW-1:0]      nbits;
  logic [2:0]           bit_idx;
  logic                 cur_bit;
  logic [NodeW-1:0]     child, next_walk;
  htd_pkg::step_flags_t flags;
  logic                 out_free;
  logic                 stall;
  logic                 advance;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Only indices of internal nodes are stored; other writes just reset the walk.
  assign wr_internal = ({1'b0, node_index_i} >= (NodeW + 1)'(NUM_SYMBOLS)) &&
                       ({1'b0, node_index_i} <  (NodeW + 1)'(TREE_NODES));
  assign ram_we      = in_xfer && (command_i == htd_pkg::CmdWrite) && wr_internal;
  assign waddr_off   = node_index_i - FirstInternal;
  assign ram_waddr   = waddr_off[AddrW-1:0];

  assign nbits   = (valid_bits_i > MaxBits) ? MaxBits : valid_bits_i;
  assign bit_idx = 3'(cnt_q - CntW'(1));
  assign cur_bit = byte_q[bit_idx];

  htd_ram #(
    .WIDTH (2 * NodeW),
    .DEPTH (IntNodes)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({left_child_i, right_child_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  htd_step #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .TREE_NODES  (TREE_NODES)
  ) u_step (
    .left_child_i  (ram_rdata[2*NodeW-1:NodeW]),
    .right_child_i (ram_rdata[NodeW-1:0]),
    .code_bit_i    (cur_bit),
    .child_o       (child),
    .next_walk_o   (next_walk),
    .flags_o       (flags)
  );

  // The output register can take a new symbol when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  // A new symbol with one already held needs room to push the held one out.
  assign stall    = flags.leaf && pend_valid_q && !out_free;
  assign advance  = (state_q == StWalk) && !stall;

  // While stalled the current node is read again so its entry stays on hand.
  assign raddr_node = advance ? next_walk : walk_q;
  assign raddr_off  = raddr_node - FirstInternal;
  assign ram_raddr  = raddr_off[AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    cnt_d        = cnt_q;
    byte_d       = byte_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (command_i == htd_pkg::CmdWrite) begin
            walk_d = RootNode;
          end else if (nbits != '0) begin
            byte_d  = code_byte_i;
            cnt_d   = nbits;
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (advance) begin
          walk_d = next_walk;
          cnt_d  = cnt_q - CntW'(1);
          if (flags.leaf) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = child[SymW-1:0];
          end
          if (cnt_q == CntW'(1)) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        // The symbol still held is the last one of this byte.
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      walk_q       <= RootNode;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = out_sym_q;
  assign last_of_byte_o = out_last_q;

  // A held symbol never outlives the byte that produced it.
  a_pend_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != StIdle))
    else $error("held symbol while idle");

  // The walk always rests on an internal node.
  a_walk_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, walk_q} >= (NodeW + 1)'(NUM_SYMBOLS)) &&
    ({1'b0, walk_q} <  (NodeW + 1)'(TREE_NODES)))
    else $error("walk position left the internal nodes");

  // Walking always has at least one code bit left.
  a_walk_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (cnt_q != '0) && (cnt_q <= MaxBits))
    else $error("walking with no code bits");

  // A stalled step leaves the walk and the bit count in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StWalk) && stall) |=> ($stable(walk_q) && $stable(cnt_q)))
    else $error("walk moved during an output stall");

endmodule

FILE: tb/sv/tb_huffman_tree_table_decode_top.sv
`timescale 1ns / 1ps
// Testbench for the Huffman tree-table decoder: table writes, tree walks and symbol checks.
module tb_huffman_tree_table_decode_top;

  // Tree geometry of the default build.
  localparam int unsigned NumSymbols = 256;
  localparam int unsigned TreeNodes  = 511;
  localparam int unsigned RootNode   = TreeNodes - 1;
  localparam int unsigned NodeW      = $clog2(TreeNodes);
  localparam int unsigned SymbolW    = $clog2(NumSymbols);
  // Child index beyond the tree: the walk goes back to the root silently.
  localparam logic [NodeW-1:0] OutsideNode = 9'h1FF;

  // One input transfer, field for field as on the ports.
  typedef struct packed {
    logic                          command;
    logic [NodeW-1:0]              node_index;
    logic [NodeW-1:0]              left_child;
    logic [NodeW-1:0]              right_child;
    logic [7:0]                    code_byte;
    logic [htd_pkg::BitCountW-1:0] valid_bits;
  } tree_cmd_t;

  // One output transfer.
  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last_of_byte;
  } symbol_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 command_i;
  logic [NodeW-1:0]     node_index_i;
  logic [NodeW-1:0]     left_child_i;
  logic [NodeW-1:0]     right_child_i;
  logic [7:0]           code_byte_i;
  logic [3:0]           valid_bits_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SymbolW-1:0]   symbol_o;
  logic                 last_of_byte_o;

  huffman_tree_table_decode_top #(
    .NUM_SYMBOLS(NumSymbols),
    .TREE_NODES (TreeNodes)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .node_index_i  (node_index_i),
    .left_child_i  (left_child_i),
    .right_child_i (right_child_i),
    .code_byte_i   (code_byte_i),
    .valid_bits_i  (valid_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_of_byte_o(last_of_byte_o)
  );

  // Our own copy of the decoder state. The child tables are indexed by the
  // node number itself, and node_written tracks which entries hold data so
  // that the stimulus never steers the walk into an entry that is undefined.
  logic [NodeW-1:0] left_child_tbl  [NumSymbols:RootNode];
  logic [NodeW-1:0] right_child_tbl [NumSymbols:RootNode];
  bit               node_written    [NumSymbols:RootNode];
  int unsigned      written_nodes   [$];
  logic [NodeW-1:0] walk_node;

  // Symbols that the decoder still owes us, oldest first.
  symbol_result_t   expected_symbols [$];
  symbol_result_t   expected_head;
  int unsigned      error_count;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The receiver draws its ready at every falling edge; with a zero stall
  // rate it simply stays high.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic bit is_internal(input logic [NodeW-1:0] node);
    return (node >= NumSymbols) && (node < TreeNodes);
  endfunction

  // Applies one accepted transfer to the state copy and queues the symbols
  // it must produce. A write stores both children of an internal node (and
  // nothing for an index outside the internal range) and always sends the
  // walk back to the root. A decode walks the low-order code bits of the
  // byte, most significant first; the count saturates at eight.
  function automatic void predict_symbols(input tree_cmd_t c);
    logic [3:0]         nbits;
    logic [NodeW-1:0]   pos;
    logic [NodeW-1:0]   nxt;
    logic [SymbolW-1:0] syms [8];
    int                 count;
    int                 k;
    symbol_result_t     r;

    if (c.command == htd_pkg::CmdWrite) begin
      if (is_internal(c.node_index)) begin
        left_child_tbl[c.node_index]  = c.left_child;
        right_child_tbl[c.node_index] = c.right_child;
        if (!node_written[c.node_index]) begin
          node_written[c.node_index] = 1'b1;
          written_nodes.insert(written_nodes.size(), int'(c.node_index));
        end
      end
      walk_node = RootNode;
      return;
    end

    nbits = (c.valid_bits > htd_pkg::BitsPerByte) ? 4'(htd_pkg::BitsPerByte) : c.valid_bits;
    count = 0;
    for (k = nbits; k > 0; k--) begin
      pos = is_internal(walk_node) ? walk_node : NodeW'(RootNode);
      nxt = c.code_byte[k-1] ? right_child_tbl[pos] : left_child_tbl[pos];
      if (nxt < NumSymbols) begin
        // A leaf: the node number is the symbol.
        syms[count] = nxt[SymbolW-1:0];
        count++;
        walk_node = RootNode;
      end else if (nxt >= TreeNodes) begin
        walk_node = RootNode;
      end else begin
        walk_node = nxt;
      end
    end

    // Only the final symbol of the byte carries the last flag.
    for (k = 0; k < count; k++) begin
      r.symbol       = syms[k];
      r.last_of_byte = (k == count - 1);
      expected_symbols.insert(expected_symbols.size(), r);
    end
  endfunction

  // Every accepted output transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected symbol, expected none, actual symbol %0d last %0b",
                 $time, symbol_o, last_of_byte_o);
        error_count++;
      end else begin
        expected_head = expected_symbols.pop_front();
        if (symbol_o !== expected_head.symbol) begin
          $display("%0t: symbol mismatch, expected %0d, actual %0d",
                   $time, expected_head.symbol, symbol_o);
          error_count++;
        end
        if (last_of_byte_o !== expected_head.last_of_byte) begin
          $display("%0t: last_of_byte mismatch on symbol %0d, expected %0b, actual %0b",
                   $time, expected_head.symbol, expected_head.last_of_byte,
                   last_of_byte_o);
          error_count++;
        end
      end
    end
  end

  // Builders for one transfer. Fields that the command does not use carry
  // random values so that they are exercised as noise.
  function automatic tree_cmd_t tree_write(input int unsigned node, input int unsigned lchild,
                                           input int unsigned rchild);
    tree_cmd_t c;
    c.command     = htd_pkg::CmdWrite;
    c.node_index  = NodeW'(node);
    c.left_child  = NodeW'(lchild);
    c.right_child = NodeW'(rchild);
    c.code_byte   = 8'($urandom);
    c.valid_bits  = 4'($urandom);
    return c;
  endfunction

  function automatic tree_cmd_t byte_decode(input logic [7:0] code, input logic [3:0] nbits);
    tree_cmd_t c;
    c.command     = htd_pkg::CmdDecode;
    c.node_index  = NodeW'($urandom);
    c.left_child  = NodeW'($urandom);
    c.right_child = NodeW'($urandom);
    c.code_byte   = code;
    c.valid_bits  = nbits;
    return c;
  endfunction

  // Drives one transfer from a falling edge, after a random number of idle
  // cycles, and waits for it to be accepted. The prediction is made at the
  // accepting edge. Valid is only lowered inside the idle loop, so it never
  // sees two assignments in one time step.
  task automatic send_item(input tree_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= c.command;
    node_index_i  <= c.node_index;
    left_child_i  <= c.left_child;
    right_child_i <= c.right_child;
    code_byte_i   <= c.code_byte;
    valid_bits_i  <= c.valid_bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_symbols(c);
  endtask

  // Picks a child for a random node write: mostly leaves, often an internal
  // node that already holds data (which keeps every reachable entry
  // defined), now and then the index beyond the tree.
  function automatic int unsigned pick_child();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, NumSymbols - 1);
    if (r < 90) return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
    return OutsideNode;
  endfunction

  // Random traffic: a steady mix of node rewrites that reshape the tree and
  // byte decodes that walk it, with a few writes outside the internal range
  // and decodes whose bit count is short, zero or above eight.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned i;
    int unsigned r;
    int unsigned node;
    logic [3:0]  nbits;
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 19) == 0) begin
          node = ($urandom_range(0, 3) == 0) ? OutsideNode : $urandom_range(0, NumSymbols - 1);
        end else begin
          node = $urandom_range(NumSymbols, RootNode);
        end
        send_item(tree_write(node, pick_child(), pick_child()));
      end else begin
        nbits = ($urandom_range(0, 99) < 70) ? 4'd8 : 4'($urandom_range(0, 15));
        send_item(byte_decode(8'($urandom), nbits));
      end
    end
  endtask

  // A small hand-built tree, then decodes and writes aimed at the corners:
  // all-ones and all-zeros bytes, a partial final byte with junk above its
  // code bits, an empty byte, bit counts above eight, children beyond the
  // tree, writes outside the internal range and writes in the middle of a
  // walk, and the extreme node and leaf numbers.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Root: 0 -> node 508, 1 -> leaf 128. Node 508: 0 -> node 509, 1 -> beyond
    // the tree. Node 509: 0 -> leaf 0, 1 -> leaf 255.
    send_item(tree_write(509, 0, 255));
    send_item(tree_write(508, 509, OutsideNode));
    send_item(tree_write(RootNode, 508, 128));
    // Eight ones give eight symbols from one byte.
    send_item(byte_decode(8'hFF, 4'd8));
    // Eight zeros leave the walk parked at node 509 across the byte boundary.
    send_item(byte_decode(8'h00, 4'd8));
    send_item(byte_decode(8'hF1, 4'd1));
    send_item(byte_decode(8'hAA, 4'd0));
    send_item(byte_decode(8'h50, 4'd15));
    send_item(byte_decode(8'h3C, 4'd9));
    send_item(byte_decode(8'h00, 4'd2));
    // Writes outside the internal range store nothing but still reset the walk.
    send_item(tree_write(0, OutsideNode, 0));
    send_item(byte_decode(8'h00, 4'd1));
    send_item(tree_write(NumSymbols - 1, RootNode, NumSymbols));
    send_item(byte_decode(8'h00, 4'd1));
    send_item(tree_write(OutsideNode, OutsideNode, OutsideNode));
    send_item(byte_decode(8'h00, 4'd2));
    // Lowest internal node, a self loop, and a root that now reaches both.
    send_item(tree_write(NumSymbols, RootNode, 3));
    send_item(tree_write(507, 507, NumSymbols));
    send_item(tree_write(RootNode, 508, 507));
    send_item(byte_decode(8'hB7, 4'd8));
    send_item(byte_decode(8'h6D, 4'd8));
    send_item(byte_decode(8'h05, 4'd3));
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(32);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    random_traffic(32);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    random_traffic(32);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    random_traffic(32);
  endtask

  // Hard stop in case the decoder hangs.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned guard;

    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    walk_node      = RootNode;
    foreach (node_written[n]) node_written[n] = 1'b0;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    command_i     = htd_pkg::CmdWrite;
    node_index_i  = '0;
    left_child_i  = '0;
    right_child_i = '0;
    code_byte_i   = '0;
    valid_bits_i  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain: wait for every owed symbol, then a few more cycles so that a
    // stray extra transfer would still be caught by the checker.
    guard = 0;
    while (expected_symbols.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_symbols.size() != 0) begin
      $display("%0t: %0d expected symbols never arrived, next expected symbol %0d last %0b",
               $time, expected_symbols.size(), expected_symbols[0].symbol,
               expected_symbols[0].last_of_byte);
      error_count++;
    end
    repeat (30) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
